>>> rtl/core/mctb_pkg.sv
// Shared types, constants and action codes of the multi-channel timeout bank.
package mctb_pkg;

	// Number of timeout channels and the width of an index into them.
	localparam int CHANNELS = 16;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Fixed field widths.
	localparam int ACT_W  = 3;
	localparam int CHAN_W = 4;
	localparam int TICK_W = 32;

	// Depth of the result queue and the widths of its pointers and fill count.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

	// Action codes of an input item; the eighth code is unused and ignored.
	typedef enum logic [ACT_W-1:0] {
		ACT_TICK     = 3'd0,
		ACT_START    = 3'd1,
		ACT_STOP     = 3'd2,
		ACT_RESTART  = 3'd3,
		ACT_SETDLY   = 3'd4,
		ACT_QUERY    = 3'd5,
		ACT_QRESTART = 3'd6
	} action_t;

	// One channel's stored state.
	typedef struct packed {
		logic [TICK_W-1:0] stamp;
		logic [TICK_W-1:0] delay;
		logic              en;
	} entry_t;

	// One result item.
	typedef struct packed {
		logic [CHAN_W-1:0] channel_out;
		logic              expired;
		logic              expired_enabled;
		logic [TICK_W-1:0] ticks_remaining;
		logic [TICK_W-1:0] delay_setting;
		logic              running;
	} result_t;

endpackage

>>> rtl/core/mctb_in_if.sv
// Input channel of the timeout bank: handshake and one command item.
interface mctb_in_if
	import mctb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [CHAN_W-1:0] channel;
	logic [TICK_W-1:0] delay_ticks;

	modport source (output valid, output action, output channel, output delay_ticks,
		input ready);
	modport sink (input valid, input action, input channel, input delay_ticks,
		output ready);
endinterface

>>> rtl/core/mctb_out_if.sv
// Output channel of the timeout bank: handshake and one query result.
interface mctb_out_if
	import mctb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] channel_out;
	logic              expired;
	logic              expired_enabled;
	logic [TICK_W-1:0] ticks_remaining;
	logic [TICK_W-1:0] delay_setting;
	logic              running;

	modport source (output valid, output channel_out, output expired,
		output expired_enabled, output ticks_remaining, output delay_setting,
		output running, input ready);
	modport sink (input valid, input channel_out, input expired,
		input expired_enabled, input ticks_remaining, input delay_setting,
		input running, output ready);
endinterface

>>> rtl/core/mctb_entry_ram.sv
// Channel state memory with registered read and per-entry valid bits.
module mctb_entry_ram
	import mctb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [CH_IDX_W-1:0] rd_addr,
	output entry_t              rd_data,
	input  logic                wr_en,
	input  logic [CH_IDX_W-1:0] wr_addr,
	input  entry_t              wr_data
);

	entry_t               mem [CHANNELS];
	logic [CHANNELS-1:0]  vld_q;
	entry_t               raw_q;
	logic                 rd_vld_q;

	// Storage array, written and read synchronously.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem[rd_addr];
		end
	end

	// Valid bits: an entry never written since reset reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? raw_q : '0;

endmodule

>>> rtl/core/mctb_out_fifo.sv
// Result queue that decouples the query pipeline from the output channel.
module mctb_out_fifo
	import mctb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  result_t              push_data,
	output logic [OUT_CNT_W-1:0] count,
	mctb_out_if.source           rsp
);

	result_t              buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 pop;
	result_t              head;

	assign pop  = rsp.valid && rsp.ready;
	assign head = buf_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUT_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OUT_CNT_W'(1);
			end
		end
	end

	assign count               = cnt_q;
	assign rsp.valid           = (cnt_q != '0);
	assign rsp.channel_out     = head.channel_out;
	assign rsp.expired         = head.expired;
	assign rsp.expired_enabled = head.expired_enabled;
	assign rsp.ticks_remaining = head.ticks_remaining;
	assign rsp.delay_setting   = head.delay_setting;
	assign rsp.running         = head.running;

endmodule

>>> rtl/core/multi_channel_timeout_bank.sv
// Top level of the multi-channel timeout bank: command decode and query pipeline.
// The bank takes one command transfer per clock cycle while ready is high. Tick
// commands advance the shared 32-bit counter in place; each in-range channel
// command reads the addressed entry from a single-port-read memory in the transfer
// cycle, and those that change it write it back in the next cycle, with the pending
// write forwarded when back-to-back commands address the same channel. A query's
// result passes through the stage-1 and stage-2 registers into a four-entry result
// queue; input ready drops only while that queue plus queries still in flight could
// not hold another result, so one command per cycle is sustained as long as results
// are taken. Reset clears all channels at once via per-channel valid bits, no sweep.
module multi_channel_timeout_bank
	import mctb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mctb_in_if.sink    req,
	mctb_out_if.source rsp
);

	logic [TICK_W-1:0]    tick_q;
	logic                 acc;
	action_t              act_in;
	logic                 in_range;
	logic                 is_chan_op;
	logic [CH_IDX_W-1:0]  idx_in;

	logic                 vld_s1;
	action_t              act_s1;
	logic [CH_IDX_W-1:0]  idx_s1;
	logic [CHAN_W-1:0]    ch_s1;
	logic [TICK_W-1:0]    dly_s1;
	logic [TICK_W-1:0]    tick_s1;
	logic                 fwd_s1;
	entry_t               fwd_entry_s1;

	entry_t               ram_rd;
	entry_t               cur_s1;
	entry_t               new_s1;
	logic                 wr_s1;
	logic                 qry_s1;

	logic                 vld_s2;
	logic [CHAN_W-1:0]    ch_s2;
	logic [TICK_W-1:0]    elapsed_s2;
	logic [TICK_W-1:0]    delay_s2;
	logic                 en_s2;

	logic                 expired_s2;
	result_t              res_s2;
	logic [OUT_CNT_W-1:0] fifo_cnt;
	logic [OUT_CNT_W-1:0] pending;

	// Input decode.
	assign acc        = req.valid && req.ready;
	assign act_in     = action_t'(req.action);
	assign in_range   = (32'(req.channel) < 32'(CHANNELS));
	assign idx_in     = CH_IDX_W'(req.channel);
	assign is_chan_op = in_range && (act_in inside {ACT_START, ACT_STOP, ACT_RESTART,
		ACT_SETDLY, ACT_QUERY, ACT_QRESTART});

	// Space check: queued results plus queries still in the pipeline.
	assign pending   = fifo_cnt + OUT_CNT_W'(qry_s1) + OUT_CNT_W'(vld_s2);
	assign req.ready = (pending < OUT_CNT_W'(OUT_DEPTH));

	// Shared tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (acc && act_in == ACT_TICK) begin
			tick_q <= tick_q + TICK_W'(1);
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc && is_chan_op;
			fwd_s1 <= acc && is_chan_op && wr_s1 && (idx_s1 == idx_in);
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1       <= act_in;
			idx_s1       <= idx_in;
			ch_s1        <= req.channel;
			dly_s1       <= req.delay_ticks;
			tick_s1      <= tick_q;
			fwd_entry_s1 <= new_s1;
		end
	end

	mctb_entry_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc && is_chan_op),
		.rd_addr (idx_in),
		.rd_data (ram_rd),
		.wr_en   (wr_s1),
		.wr_addr (idx_s1),
		.wr_data (new_s1)
	);

	// Modify step: the entry as it stands, then the updated entry for write-back.
	assign cur_s1 = fwd_s1 ? fwd_entry_s1 : ram_rd;
	assign qry_s1 = vld_s1 && (act_s1 inside {ACT_QUERY, ACT_QRESTART});

	always_comb begin
		new_s1 = cur_s1;
		wr_s1  = 1'b0;
		if (vld_s1) begin
			case (act_s1)
				ACT_START: begin
					new_s1.stamp = tick_s1;
					new_s1.en    = 1'b1;
					wr_s1        = 1'b1;
				end
				ACT_STOP: begin
					new_s1.en = 1'b0;
					wr_s1     = 1'b1;
				end
				ACT_RESTART, ACT_QRESTART: begin
					new_s1.stamp = tick_s1;
					wr_s1        = 1'b1;
				end
				ACT_SETDLY: begin
					new_s1.delay = dly_s1;
					wr_s1        = 1'b1;
				end
				default: begin
					wr_s1 = 1'b0;
				end
			endcase
		end
	end

	// Stage 2: elapsed ticks of the queried channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= qry_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (qry_s1) begin
			ch_s2      <= ch_s1;
			elapsed_s2 <= tick_s1 - cur_s1.stamp;
			delay_s2   <= cur_s1.delay;
			en_s2      <= cur_s1.en;
		end
	end

	// Expiry compare and remaining time.
	assign expired_s2             = (elapsed_s2 > delay_s2);
	assign res_s2.channel_out     = ch_s2;
	assign res_s2.expired         = expired_s2;
	assign res_s2.expired_enabled = expired_s2 && en_s2;
	assign res_s2.ticks_remaining = expired_s2 ? '0 : (delay_s2 - elapsed_s2);
	assign res_s2.delay_setting   = delay_s2;
	assign res_s2.running         = en_s2;

	mctb_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s2),
		.push_data (res_s2),
		.count     (fifo_cnt),
		.rsp       (rsp)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench of the timeout bank: directed table plus random command traffic, checked by a model.
module tb;
	import mctb_pkg::*;

	// The eighth action code is not decoded by the bank.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 500;
	localparam result_t NO_WANT = '0;

	typedef struct {
		logic [ACT_W-1:0]  action;
		logic [CHAN_W-1:0] channel;
		logic [TICK_W-1:0] delay_ticks;
		bit                typed;
		result_t           want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mctb_in_if  req_if();
	mctb_out_if rsp_if();

	multi_channel_timeout_bank DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Shadow copy of the bank: shared counter and per-channel stamp, delay and enable.
	logic [TICK_W-1:0] shadow_ticks;
	logic [TICK_W-1:0] shadow_stamp [CHANNELS];
	logic [TICK_W-1:0] shadow_delay [CHANNELS];
	logic              shadow_en [CHANNELS];

	result_t pending_reports [$];
	int      errors = 0;
	int      items_sent = 0;
	bit      steady = 1'b0;

	// Directed rows. Typed results follow directly from the commands above them.
	row_t script [24] = '{
		'{ACT_QUERY,    4'd0,  32'd0,         1'b1, '{4'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0}},
		'{ACT_SETDLY,   4'd15, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ACT_QUERY,    4'd15, 32'd0,         1'b1,
			'{4'd15, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
		'{ACT_START,    4'd15, 32'd0,         1'b0, NO_WANT},
		'{ACT_QUERY,    4'd15, 32'd0,         1'b1,
			'{4'd15, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
		'{ACT_TICK,     4'd9,  32'h1234_5678, 1'b0, NO_WANT},
		'{ACT_QUERY,    4'd0,  32'd0,         1'b1, '{4'd0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0}},
		'{ACT_START,    4'd0,  32'd0,         1'b0, NO_WANT},
		'{ACT_TICK,     4'd0,  32'd0,         1'b0, NO_WANT},
		'{ACT_QRESTART, 4'd0,  32'd0,         1'b1, '{4'd0, 1'b1, 1'b1, 32'd0, 32'd0, 1'b1}},
		'{ACT_QUERY,    4'd0,  32'd0,         1'b1, '{4'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b1}},
		'{ACT_STOP,     4'd0,  32'd0,         1'b0, NO_WANT},
		'{ACT_TICK,     4'd0,  32'd0,         1'b0, NO_WANT},
		'{ACT_QUERY,    4'd0,  32'd0,         1'b1, '{4'd0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0}},
		'{ACT_SETDLY,   4'd5,  32'd1,         1'b0, NO_WANT},
		'{ACT_RESTART,  4'd5,  32'd0,         1'b0, NO_WANT},
		'{ACT_TICK,     4'd0,  32'd0,         1'b0, NO_WANT},
		'{ACT_QUERY,    4'd5,  32'd0,         1'b1, '{4'd5, 1'b0, 1'b0, 32'd0, 32'd1, 1'b0}},
		'{ACT_TICK,     4'd0,  32'd0,         1'b0, NO_WANT},
		'{ACT_QUERY,    4'd5,  32'd0,         1'b1, '{4'd5, 1'b1, 1'b0, 32'd0, 32'd1, 1'b0}},
		'{ACT_UNUSED,   4'd3,  32'hDEAD_BEEF, 1'b0, NO_WANT},
		'{ACT_QUERY,    4'd3,  32'd0,         1'b0, NO_WANT},
		'{ACT_SETDLY,   4'd7,  32'h8000_0000, 1'b0, NO_WANT},
		'{ACT_QRESTART, 4'd7,  32'hFFFF_FFFF, 1'b0, NO_WANT}
	};

	// Free-running clock.
	always #5 clk = ~clk;

	// Hard stop in case the bank hangs.
	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// Applies one accepted command to the shadow bank; returns 1 with the report for queries.
	function automatic bit timeout_step(input logic [ACT_W-1:0] act,
		input logic [CHAN_W-1:0] ch, input logic [TICK_W-1:0] dly, output result_t res);
		logic [TICK_W-1:0] elapsed;
		bit                late;
		res = '0;
		if (act == ACT_TICK) begin
			shadow_ticks = shadow_ticks + 1'b1;
			return 1'b0;
		end
		if (int'(ch) >= CHANNELS)
			return 1'b0;
		case (act)
			ACT_START: begin
				shadow_stamp[ch] = shadow_ticks;
				shadow_en[ch] = 1'b1;
				return 1'b0;
			end
			ACT_STOP: begin
				shadow_en[ch] = 1'b0;
				return 1'b0;
			end
			ACT_RESTART: begin
				shadow_stamp[ch] = shadow_ticks;
				return 1'b0;
			end
			ACT_SETDLY: begin
				shadow_delay[ch] = dly;
				return 1'b0;
			end
			ACT_QUERY, ACT_QRESTART: ;
			default: return 1'b0;
		endcase
		// Elapsed is a plain modulo difference, so a stamp from before a wrap still works.
		elapsed = shadow_ticks - shadow_stamp[ch];
		late = elapsed > shadow_delay[ch];
		res.channel_out = ch;
		res.expired = late;
		res.expired_enabled = late && shadow_en[ch];
		res.ticks_remaining = late ? '0 : shadow_delay[ch] - elapsed;
		res.delay_setting = shadow_delay[ch];
		res.running = shadow_en[ch];
		if (act == ACT_QRESTART)
			shadow_stamp[ch] = shadow_ticks;
		return 1'b1;
	endfunction

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [TICK_W-1:0] got,
		input logic [TICK_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Drives one command transfer and records the report it should cause.
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] ch,
		input logic [TICK_W-1:0] dly, input bit typed, input result_t want);
		int      gap;
		result_t res;
		gap = idle_len();
		repeat (gap) begin
			@(negedge clk);
			req_if.valid = 1'b0;
		end
		@(negedge clk);
		req_if.valid = 1'b1;
		req_if.action = act;
		req_if.channel = ch;
		req_if.delay_ticks = dly;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		if (act != ACT_UNUSED)
			items_sent++;
		if (timeout_step(act, ch, dly, res))
			pending_reports.push_back(typed ? want : res);
	endtask

	task automatic send_plain(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] ch,
		input logic [TICK_W-1:0] dly);
		send_item(act, ch, dly, 1'b0, NO_WANT);
	endtask

	task automatic send_noise();
		send_plain(ACT_W'($urandom_range(0, 7)), CHAN_W'($urandom_range(0, 15)), $urandom);
	endtask

	// Arms one channel with a delay, then ticks around the deadline while probing it.
	task automatic run_timeout_case();
		logic [CHAN_W-1:0] ch;
		logic [TICK_W-1:0] dly;
		int                span;
		ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
		dly = ($urandom_range(0, 7) == 0) ? $urandom : TICK_W'($urandom_range(0, 6));
		if ($urandom_range(0, 15) == 0)
			dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
		send_plain(ACT_SETDLY, ch, dly);
		send_plain(($urandom_range(0, 3) == 0) ? ACT_RESTART : ACT_START, ch, $urandom);
		span = $urandom_range(0, 10);
		repeat (span) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: send_plain(ACT_TICK, CHAN_W'($urandom), $urandom);
				5, 6: send_plain(ACT_QUERY, ch, $urandom);
				7: send_plain(ACT_QRESTART, ch, $urandom);
				8: send_plain(($urandom_range(0, 1) == 0) ? ACT_STOP : ACT_START, ch, $urandom);
				default: send_noise();
			endcase
		end
		send_plain(($urandom_range(0, 2) == 0) ? ACT_QRESTART : ACT_QUERY, ch, $urandom);
	endtask

	// Result side: random back-pressure on ready.
	initial begin : result_ready
		int n;
		rsp_if.ready = 1'b0;
		forever begin
			n = idle_len();
			repeat (n) begin
				@(negedge clk);
				rsp_if.ready = 1'b0;
			end
			@(negedge clk);
			rsp_if.ready = 1'b1;
		end
	end

	// Compare each result transfer against the oldest outstanding report.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("result transfer with no query outstanding");
			end else begin
				want = pending_reports.pop_front();
				compare_field("channel_out", TICK_W'(rsp_if.channel_out),
					TICK_W'(want.channel_out));
				compare_field("expired", TICK_W'(rsp_if.expired), TICK_W'(want.expired));
				compare_field("expired_enabled", TICK_W'(rsp_if.expired_enabled),
					TICK_W'(want.expired_enabled));
				compare_field("ticks_remaining", rsp_if.ticks_remaining, want.ticks_remaining);
				compare_field("delay_setting", rsp_if.delay_setting, want.delay_setting);
				compare_field("running", TICK_W'(rsp_if.running), TICK_W'(want.running));
			end
		end
	end

	// Reset, directed table, random traffic, drain.
	initial begin : stimulus
		req_if.valid = 1'b0;
		req_if.action = ACT_TICK;
		req_if.channel = '0;
		req_if.delay_ticks = '0;
		shadow_ticks = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			shadow_stamp[k] = '0;
			shadow_delay[k] = '0;
			shadow_en[k] = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i])
			send_item(script[i].action, script[i].channel, script[i].delay_ticks,
				script[i].typed, script[i].want);

		// The counter cannot wrap within a run of this length; stamps stay at or below it.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 7)
				run_timeout_case();
			else
				repeat ($urandom_range(1, 8)) send_noise();
		end
		steady = 1'b0;
		@(negedge clk);
		req_if.valid = 1'b0;

		wait (pending_reports.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
